// File: rtl/xoroshiro_range_generator_top_macros.svh
// Assertion macros shared by the range generator modules.
// Each macro expects clk and rst in scope at the point of use.
`ifndef XOROSHIRO_RANGE_GENERATOR_TOP_MACROS_SVH
`define XOROSHIRO_RANGE_GENERATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XRG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Consequent must hold in the cycle after the antecedent.
`define XRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

// Condition must never be true.
`define XRG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: lbl");

`endif

// File: rtl/xrg_pkg.sv
// Shared types and constants for the xoroshiro128+ range generator.
// No dependencies; every other RTL module imports this package.
package xrg_pkg;

  localparam int unsigned WORD_W = 64;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // Generator constants
  localparam int unsigned ROT_A   = 55;
  localparam int unsigned SHIFT_B = 14;
  localparam int unsigned ROT_C   = 36;

  localparam logic [WORD_W-1:0] SEED0_RESET = WORD_W'(1);
  localparam logic [WORD_W-1:0] SEED1_RESET = WORD_W'(0);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED0 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED1 = 1'b1;

  // Request kinds
  localparam logic [1:0] REQ_RAW  = 2'd0;
  localparam logic [1:0] REQ_UPTO = 2'd1;
  localparam logic [1:0] REQ_SPAN = 2'd2;

  // Job queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic {
    OP_PASS = 1'b0,
    OP_MOD  = 1'b1
  } xrg_op_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [WORD_W-1:0] bound_low;
    logic [WORD_W-1:0] bound_high;
  } xrg_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              range_error;
  } xrg_rsp_t;

  // operand: result for OP_PASS, dividend for OP_MOD
  // bound:   divisor minus one; offset is added to the remainder
  typedef struct packed {
    xrg_op_t           op;
    logic [WORD_W-1:0] operand;
    logic [WORD_W-1:0] bound;
    logic [WORD_W-1:0] offset;
    logic              err;
  } xrg_job_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned amt);
    rotl = (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

// File: rtl/xrg_front.sv
// Front end: holds the generator state, accepts requests and classifies them
// into queue jobs. Depends on xrg_pkg.
module xrg_front
  import xrg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  xrg_req_t             req,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output xrg_job_t             q_job
);

  logic [WORD_W-1:0] gen0;
  logic [WORD_W-1:0] gen1;
  logic [WORD_W-1:0] gen0_next;
  logic [WORD_W-1:0] gen1_next;
  logic [WORD_W-1:0] raw_sum;
  logic [WORD_W-1:0] mix;
  logic [WORD_W:0]   span;
  logic              adv;

  assign raw_sum   = gen0 + gen1;
  assign mix       = gen0 ^ gen1;
  assign gen0_next = rotl(gen0, ROT_A) ^ mix ^ (mix << SHIFT_B);
  assign gen1_next = rotl(mix, ROT_C);

  // span[WORD_W] is the borrow: low above high
  assign span = {1'b0, req.bound_high} - {1'b0, req.bound_low};

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  always_comb begin
    adv           = 1'b0;
    q_job.op      = OP_PASS;
    q_job.operand = '0;
    q_job.bound   = req.bound_high;
    q_job.offset  = '0;
    q_job.err     = 1'b0;
    case (req.req_type)
      REQ_RAW: begin
        adv           = 1'b1;
        q_job.operand = raw_sum;
      end
      REQ_UPTO: begin
        if (req.bound_high == ALL_ONES) begin
          adv           = 1'b1;
          q_job.operand = raw_sum;
        end else if (req.bound_high != '0) begin
          adv           = 1'b1;
          q_job.op      = OP_MOD;
          q_job.operand = raw_sum;
        end
      end
      REQ_SPAN: begin
        if (span[WORD_W]) begin
          q_job.err = 1'b1;
        end else if (req.bound_high == ALL_ONES) begin
          adv           = 1'b1;
          q_job.operand = raw_sum;
        end else if (span[WORD_W-1:0] == '0) begin
          q_job.operand = req.bound_low;
        end else begin
          adv           = 1'b1;
          q_job.op      = OP_MOD;
          q_job.operand = raw_sum;
          q_job.bound   = span[WORD_W-1:0];
          q_job.offset  = req.bound_low;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen0 <= SEED0_RESET;
      gen1 <= SEED1_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEED0: gen0 <= cfg_data;
        CFG_SEED1: gen1 <= cfg_data;
        default: begin
        end
      endcase
    end else if (q_push && adv) begin
      gen0 <= gen0_next;
      gen1 <= gen1_next;
    end
  end

endmodule

// File: rtl/xrg_queue.sv
// Short job queue between front and back end, register based.
// Depends on xrg_pkg and the assertion macro header.
`include "xoroshiro_range_generator_top_macros.svh"

module xrg_queue
  import xrg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  xrg_job_t push_job,
  output logic     full,
  input  logic     pop,
  output xrg_job_t pop_job,
  output logic     empty
);

  xrg_job_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `XRG_ASSERT_NEVER(a_no_push_full, push && full)
  `XRG_ASSERT_NEVER(a_no_pop_empty, pop && empty)
  `XRG_ASSERT_NEXT(a_ptr_gap, push && !pop && count == '0, wptr != rptr || full)

endmodule

// File: rtl/xrg_back.sv
// Back end: takes jobs from the queue, runs the restoring divider for
// range reduction and holds the output register. Depends on xrg_pkg, macros.
`include "xoroshiro_range_generator_top_macros.svh"

module xrg_back
  import xrg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  xrg_job_t q_job,
  output logic     q_pop,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output xrg_rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [DCNT_W-1:0] CNT_LAST = DCNT_W'(DIV_STEPS - 1);

  state_t            state;
  logic [DCNT_W-1:0] cnt;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] bnd;
  logic [WORD_W-1:0] off;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   reduced;
  logic [WORD_W-1:0] rem_next;
  logic              take;
  logic              out_free;
  logic              rsp_load;

  // Divisor is bnd + 1, so subtract by adding ~bnd
  assign shifted  = {rem, dvd[WORD_W-1]};
  assign take     = shifted > {1'b0, bnd};
  assign reduced  = shifted + {1'b1, ~bnd};
  assign rem_next = take ? reduced[WORD_W-1:0] : shifted[WORD_W-1:0];

  assign out_free = !rsp_valid || !rsp_stall;
  assign q_pop    = !q_empty && (state == S_IDLE) && (q_job.op == OP_MOD || out_free);
  assign rsp_load = (state == S_IDLE && q_pop && q_job.op == OP_PASS) ||
                    (state == S_DONE && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_job.op == OP_MOD) begin
              dvd   <= q_job.operand;
              rem   <= '0;
              bnd   <= q_job.bound;
              off   <= q_job.offset;
              cnt   <= '0;
              state <= S_DIV;
            end else begin
              rsp.value       <= q_job.operand;
              rsp.range_error <= q_job.err;
            end
          end
        end
        S_DIV: begin
          rem <= rem_next;
          dvd <= dvd << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the remainder until the output register frees up
          if (out_free) begin
            rsp.value       <= rem + off;
            rsp.range_error <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `XRG_ASSERT_IMPLY(a_rem_below_divisor, state != S_IDLE, rem <= bnd)
  `XRG_ASSERT_NEXT(a_div_ends, state == S_DIV && cnt == CNT_LAST, state == S_DONE)
  `XRG_ASSERT_IMPLY(a_rsp_source, $rose(rsp_valid),
    $past(state) == S_IDLE || $past(state) == S_DONE)

endmodule

// File: rtl/xoroshiro_range_generator_top.sv
// Top level of the xoroshiro128+ range generator: front end, job queue and
// divider back end. Depends on xrg_pkg, xrg_front, xrg_queue and xrg_back.
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------
//   request   | req_valid / req_stall  | req  (req_type, bound_low, high)
//   response  | rsp_valid / rsp_stall  | rsp  (value, range_error)
//   config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Raw, saturated and error requests bypass the divider.
// A range-reduced request runs the 64-step restoring divider, one step per quotient
// bit, between load and output; the back end takes no new job until it is done.
// Up to two requests queue ahead of the divider; req_stall rises when full.
// Reset loads the state with 1 and 0; no clearing pass is needed.
module xoroshiro_range_generator_top
  import xrg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  xrg_req_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output xrg_rsp_t             rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  xrg_job_t push_job;
  xrg_job_t pop_job;

  assign cfg_ready = 1'b1;

  xrg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  xrg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  xrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: bench/tb_xoroshiro_range_generator_top.sv
// Testbench for xoroshiro_range_generator_top: random and directed draw requests
// are checked against a cycle-free model of the generator and range reduction.
// Depends on xrg_pkg and the RTL under rtl/.
module tb_xoroshiro_range_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xrg_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_LEN = 1000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  xrg_req_t             req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  xrg_rsp_t             rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  // model copy of the generator state
  logic [WORD_W-1:0] gen_s0 = SEED0_RESET;
  logic [WORD_W-1:0] gen_s1 = SEED1_RESET;

  xrg_rsp_t pending_draws[$];
  int       fail_cnt = 0;
  int       send_idle_pct = 0;
  int       rsp_stall_pct = 0;
  int       hold_reqs = 0;
  int       hold_done = 0;

  xoroshiro_range_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // Return the raw sum and advance the generator.
  function automatic logic [WORD_W-1:0] next_raw();
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] sum;
    a = gen_s0;
    b = gen_s1;
    sum = a + b;
    b = b ^ a;
    gen_s0 = ((a << ROT_A) | (a >> (WORD_W - ROT_A))) ^ b ^ (b << SHIFT_B);
    gen_s1 = (b << ROT_C) | (b >> (WORD_W - ROT_C));
    return sum;
  endfunction

  // Draw in [0, n]; a zero bound draws nothing, an all-ones bound is the raw value.
  function automatic logic [WORD_W-1:0] draw_upto(input logic [WORD_W-1:0] n);
    if (n == '0) return '0;
    if (n == ALL_ONES) return next_raw();
    return next_raw() % (n + 1'b1);
  endfunction

  function automatic xrg_rsp_t predict_draw(input xrg_req_t r);
    xrg_rsp_t o;
    o = '0;
    case (r.req_type)
      REQ_RAW: begin
        o.value = next_raw();
      end
      REQ_UPTO: begin
        o.value = draw_upto(r.bound_high);
      end
      REQ_SPAN: begin
        if (r.bound_low > r.bound_high) o.range_error = 1'b1;
        else if (r.bound_high == ALL_ONES) o.value = next_raw();
        else o.value = draw_upto(r.bound_high - r.bound_low) + r.bound_low;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(4))
      0: w = {$urandom, $urandom};
      1: w = WORD_W'($urandom_range(15));
      2: w = ALL_ONES - WORD_W'($urandom_range(3));
      default: w = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    return w;
  endfunction

  function automatic xrg_req_t rand_req();
    xrg_req_t r;
    logic [WORD_W-1:0] t;
    int k;
    k = $urandom_range(99);
    r.bound_low = rand_word();
    r.bound_high = rand_word();
    if (k < 20) begin
      r.req_type = REQ_RAW;
    end else if (k < 58) begin
      r.req_type = REQ_UPTO;
    end else if (k < 95) begin
      r.req_type = REQ_SPAN;
      // keep most spans ordered, leave a few reversed
      if (r.bound_low > r.bound_high && $urandom_range(9) != 0) begin
        t = r.bound_low;
        r.bound_low = r.bound_high;
        r.bound_high = t;
      end
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // Offer one request beat; returns at the edge where it is taken.
  task automatic send_req(input xrg_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    pending_draws.push_back(predict_draw(r));
  endtask

  task automatic send_req_fields(input logic [1:0] kind, input logic [WORD_W-1:0] lo,
                                 input logic [WORD_W-1:0] hi);
    xrg_req_t r;
    r.req_type = kind;
    r.bound_low = lo;
    r.bound_high = hi;
    send_req(r);
  endtask

  // Drop valid and let every outstanding draw come back.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_seeds(input logic [WORD_W-1:0] s0, input logic [WORD_W-1:0] s1);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SEED0;
    cfg_data <= s0;
    do @(posedge clk); while (!cfg_ready);
    gen_s0 = s0;
    cfg_index <= CFG_SEED1;
    cfg_data <= s1;
    do @(posedge clk); while (!cfg_ready);
    gen_s1 = s1;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    repeat (3) send_req_fields(REQ_RAW, '0, '0);
    send_req_fields(REQ_UPTO, '0, 64'd1000);
    wait_idle();
  endtask

  task automatic test_special_cases();
    load_seeds(ALL_ONES, 64'h0123_4567_89ab_cdef);
    send_req_fields(REQ_RAW, ALL_ONES, ALL_ONES);
    send_req_fields(REQ_UPTO, ALL_ONES, '0);
    send_req_fields(REQ_UPTO, '0, 64'd1);
    send_req_fields(REQ_UPTO, '0, ALL_ONES);
    send_req_fields(REQ_UPTO, '0, ALL_ONES - 1'b1);
    send_req_fields(REQ_UPTO, '0, 64'h8000_0000_0000_0000);
    send_req_fields(REQ_SPAN, 64'd5, 64'd5);
    send_req_fields(REQ_SPAN, 64'd9, 64'd3);
    send_req_fields(REQ_SPAN, ALL_ONES, '0);
    send_req_fields(REQ_SPAN, '0, ALL_ONES);
    send_req_fields(REQ_SPAN, 64'd7, ALL_ONES);
    send_req_fields(REQ_SPAN, ALL_ONES, ALL_ONES);
    send_req_fields(REQ_SPAN, '0, ALL_ONES - 1'b1);
    send_req_fields(REQ_SPAN, 64'd1, ALL_ONES - 1'b1);
    send_req_fields(REQ_SPAN, 64'd100, 64'd107);
    send_req_fields(REQ_UNUSED, ALL_ONES, ALL_ONES);
    wait_idle();
  endtask

  // All-zero state is a fixed point of the generator.
  task automatic test_zero_state();
    load_seeds('0, '0);
    send_req_fields(REQ_RAW, '0, '0);
    send_req_fields(REQ_UPTO, '0, 64'd10);
    send_req_fields(REQ_SPAN, 64'd3, 64'd8);
    send_req_fields(REQ_RAW, '0, '0);
    wait_idle();
  endtask

  task automatic test_random_mix(input int idle_pct, input int stall_pct, input int n,
                                 input logic [WORD_W-1:0] s0, input logic [WORD_W-1:0] s1);
    load_seeds(s0, s1);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (n) send_req(rand_req());
    wait_idle();
  endtask

  // Hold the response side off while requests keep coming, so the queue fills.
  task automatic test_backpressure();
    xrg_req_t r;
    load_seeds({$urandom, $urandom}, {$urandom, $urandom});
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_reqs++;
    repeat (12) begin
      r = rand_req();
      r.req_type = REQ_UPTO;
      if (r.bound_high == '0 || r.bound_high == ALL_ONES) r.bound_high = 64'd12345;
      send_req(r);
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      rsp_stall <= 1'b1;
      repeat (HOLD_LEN) @(posedge clk);
    end
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  always @(posedge clk) begin : check_draws
    xrg_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected draw beat: value %h range_error %b", rsp.value, rsp.range_error);
        fail_cnt++;
      end else begin
        want = pending_draws.pop_front();
        if (rsp.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, rsp.value);
          fail_cnt++;
        end
        if (rsp.range_error !== want.range_error) begin
          $error("range_error: expected %b, got %b", want.range_error, rsp.range_error);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_special_cases();
    test_zero_state();
    test_random_mix(0, 0, 220, {$urandom, $urandom}, {$urandom, $urandom});
    test_random_mix(62, 0, 220, ALL_ONES, '0);
    test_random_mix(0, 62, 220, '0, ALL_ONES);
    test_random_mix(19, 19, 220, {$urandom, $urandom}, {$urandom, $urandom});
    test_backpressure();
    if (pending_draws.size() != 0) begin
      $error("%0d draws never returned", pending_draws.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/xrg_pkg.sv
rtl/xrg_front.sv
rtl/xrg_queue.sv
rtl/xrg_back.sv
rtl/xoroshiro_range_generator_top.sv
bench/tb_xoroshiro_range_generator_top.sv
